FILE: sv/edsr_pkg.sv
// Shared package for the DER to raw signature converter.
// Holds sizes, tag constants, the parse phase enum and the front-to-back command.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package edsr_pkg;

  // Size of one coordinate in the raw form
  localparam int COORD_BYTES = 32;
  localparam int PAD_W       = $clog2(COORD_BYTES + 1);
  localparam int LEFT_W      = $clog2(COORD_BYTES + 2);

  // DER tags and limits
  localparam logic [7:0] SEQ_TAG   = 8'h30;
  localparam logic [7:0] INT_TAG   = 8'h02;
  localparam logic [7:0] LEN_MAX   = 8'(COORD_BYTES + 1);
  localparam logic [3:0] MIN_TOTAL = 4'd8;

  // Command queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    PH_SEQ_TAG = 4'd0,
    PH_SEQ_LEN = 4'd1,
    PH_R_TAG   = 4'd2,
    PH_R_LEN   = 4'd3,
    PH_R_DATA  = 4'd4,
    PH_S_TAG   = 4'd5,
    PH_S_LEN   = 4'd6,
    PH_S_DATA  = 4'd7,
    PH_DONE    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // One front-end decision: zero padding, then an optional byte, then an optional status
  typedef struct packed {
    logic [PAD_W-1:0] pad;
    logic             has_byte;
    logic [7:0]       data;
    logic             has_status;
    logic             ok;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/edsr_front.sv
// Front end: parses the DER byte stream and issues output commands.
// Depends on edsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edsr_front
  import edsr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_der_byte,
  input  wire logic       in_end_of_sig,
  input  wire logic       q_full,
  output logic            push_valid,
  output cmd_t            push_cmd
);

  phase_t            phase_r,  phase_nxt;
  logic [LEFT_W-1:0] left_r,   left_nxt;
  logic [3:0]        seen_r,   seen_nxt;
  logic              failed_r, failed_nxt;
  logic              strip_r,  strip_nxt;

  logic              accept;
  logic [LEFT_W-1:0] left_after;
  phase_t            after_int;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEQ_TAG;
      left_r   <= '0;
      seen_r   <= '0;
      failed_r <= 1'b0;
      strip_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      seen_r   <= seen_nxt;
      failed_r <= failed_nxt;
      strip_r  <= strip_nxt;
    end
  end

  // Next state and command
  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    seen_nxt   = seen_r;
    failed_nxt = failed_r;
    strip_nxt  = strip_r;
    push_cmd   = '0;
    push_valid = 1'b0;
    left_after = (left_r != '0) ? left_r - LEFT_W'(1) : '0;
    after_int  = (phase_r == PH_R_LEN || phase_r == PH_R_DATA) ? PH_S_TAG : PH_DONE;

    if (accept) begin
      if (seen_r < MIN_TOTAL) seen_nxt = seen_r + 4'd1;

      if (!failed_r) begin
        unique case (phase_r) inside
          PH_SEQ_TAG: begin
            if (in_der_byte != SEQ_TAG) failed_nxt = 1'b1;
            else phase_nxt = PH_SEQ_LEN;
          end
          PH_SEQ_LEN: begin
            phase_nxt = PH_R_TAG;
          end
          PH_R_TAG, PH_S_TAG: begin
            if (in_der_byte != INT_TAG) failed_nxt = 1'b1;
            else phase_nxt = (phase_r == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
          end
          PH_R_LEN, PH_S_LEN: begin
            if (in_der_byte > LEN_MAX) begin
              failed_nxt = 1'b1;
            end else if (in_der_byte == LEN_MAX) begin
              left_nxt  = in_der_byte[LEFT_W-1:0];
              strip_nxt = 1'b1;
              phase_nxt = (phase_r == PH_R_LEN) ? PH_R_DATA : PH_S_DATA;
            end else begin
              // short integer: left-pad with zeros now
              push_cmd.pad = PAD_W'(COORD_BYTES) - in_der_byte[PAD_W-1:0];
              left_nxt     = in_der_byte[LEFT_W-1:0];
              if (in_der_byte != 8'd0)
                phase_nxt = (phase_r == PH_R_LEN) ? PH_R_DATA : PH_S_DATA;
              else
                phase_nxt = after_int;
            end
          end
          PH_R_DATA, PH_S_DATA: begin
            if (strip_r) begin
              // leading zero of an over-long integer is dropped
              strip_nxt = 1'b0;
              if (in_der_byte != 8'd0) failed_nxt = 1'b1;
              else left_nxt = left_r - LEFT_W'(1);
            end else begin
              push_cmd.has_byte = 1'b1;
              push_cmd.data     = in_der_byte;
              left_nxt          = left_after;
              if (left_after == '0) phase_nxt = after_int;
            end
          end
          default: ;
        endcase
      end

      // End of signature: status, then back to reset state
      if (in_end_of_sig) begin
        push_cmd.has_status = 1'b1;
        push_cmd.ok = !failed_nxt && (phase_nxt == PH_DONE) && (seen_nxt >= MIN_TOTAL);
        phase_nxt  = PH_SEQ_TAG;
        left_nxt   = '0;
        seen_nxt   = '0;
        failed_nxt = 1'b0;
        strip_nxt  = 1'b0;
      end

      push_valid = (push_cmd.pad != '0) || push_cmd.has_byte || push_cmd.has_status;
    end
  end

endmodule

`default_nettype wire

FILE: sv/edsr_queue.sv
// Small command queue between the parser front end and the output back end.
// Depends on edsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edsr_queue
  import edsr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  input  cmd_t      push_cmd,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head_cmd,
  input  wire logic pop
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + QCNT_W'(1);
    else if (!do_push && do_pop) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

`default_nettype wire

FILE: sv/edsr_back.sv
// Back end: expands queued commands into result items, one per cycle while out_ready allows,
// through a registered output stage. Depends on edsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edsr_back
  import edsr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_result_kind,
  output logic       out_last_of_run
);

  logic [PAD_W-1:0] pad_cnt_r, pad_cnt_nxt;
  logic             byte_done_r, byte_done_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  kind_t            out_kind_r;
  logic             out_last_r;

  logic             step, emit_pad, emit_byte, is_last;
  logic [7:0]       item_byte;
  kind_t            item_kind;
  logic             item_last;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_result_kind = out_kind_r;
  assign out_last_of_run = out_last_r;

  // Pick the next element of the head command
  always_comb begin
    step      = head_valid && (!out_valid_r || out_ready);
    emit_pad  = (pad_cnt_r != head_cmd.pad);
    emit_byte = !emit_pad && head_cmd.has_byte && !byte_done_r;
    if (emit_pad) begin
      item_byte = 8'd0;
      item_kind = KIND_BYTE;
      item_last = 1'b0;
      is_last   = (pad_cnt_r + PAD_W'(1) == head_cmd.pad) &&
                  !head_cmd.has_byte && !head_cmd.has_status;
    end else if (emit_byte) begin
      item_byte = head_cmd.data;
      item_kind = KIND_BYTE;
      item_last = 1'b0;
      is_last   = !head_cmd.has_status;
    end else begin
      item_byte = 8'd0;
      item_kind = head_cmd.ok ? KIND_OK : KIND_ERR;
      item_last = 1'b1;
      is_last   = 1'b1;
    end
    pop = step && is_last;

    pad_cnt_nxt   = pad_cnt_r;
    byte_done_nxt = byte_done_r;
    if (step) begin
      if (is_last) begin
        pad_cnt_nxt   = '0;
        byte_done_nxt = 1'b0;
      end else if (emit_pad) begin
        pad_cnt_nxt = pad_cnt_r + PAD_W'(1);
      end else if (emit_byte) begin
        byte_done_nxt = 1'b1;
      end
    end

    if (step) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_cnt_r   <= '0;
      byte_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pad_cnt_r   <= pad_cnt_nxt;
      byte_done_r <= byte_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r <= item_byte;
      out_kind_r <= item_kind;
      out_last_r <= item_last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ecdsa_der_to_raw_signature_core.sv
// DER to raw R||S ECDSA signature converter, top level.
// Throughput: one DER byte per cycle in, one result per cycle out when out_ready
// allows; a length byte that needs padding expands into up to 32 zero bytes.
// The first result of a byte goes through the command queue write, then the
// output register. Input stalls when the four-entry command queue is full.
// Reset (synchronous, rst_n low) empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module ecdsa_der_to_raw_signature_core
  import edsr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_der_byte,
  input  wire logic       in_end_of_sig,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_result_kind,
  output logic            out_last_of_run
);

  logic push_valid, q_full, head_valid, pop;
  cmd_t push_cmd, head_cmd;

  // Parser
  edsr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_der_byte   (in_der_byte),
    .in_end_of_sig (in_end_of_sig),
    .q_full        (q_full),
    .push_valid    (push_valid),
    .push_cmd      (push_cmd)
  );

  // Command queue
  edsr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  // Result generator
  edsr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_result_kind (out_result_kind),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

FILE: dv/ecdsa_der_to_raw_signature_core_test.sv
// Self-checking testbench for the DER to raw R||S signature converter.
// Streams directed and random DER signatures, predicts the raw bytes and status items.
// Depends on edsr_pkg and ecdsa_der_to_raw_signature_core.
`timescale 1ns / 1ps

module ecdsa_der_to_raw_signature_core_test;
  import edsr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } raw_item_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_der_byte;
  logic       in_end_of_sig;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic [1:0] out_result_kind;
  logic       out_last_of_run;

  ecdsa_der_to_raw_signature_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_der_byte     (in_der_byte),
    .in_end_of_sig   (in_end_of_sig),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_result_kind (out_result_kind),
    .out_last_of_run (out_last_of_run)
  );

  // Expected raw bytes and status items, oldest first
  raw_item_t  pending_raw[$];
  // DER bytes of the signature about to be sent
  logic [7:0] der_stream[$];

  // Parser state of the prediction
  phase_t            sig_phase;
  logic [LEFT_W-1:0] int_left;
  logic [3:0]        seen_bytes;
  logic              sig_failed;
  logic              strip_zero;

  // Run bookkeeping
  int   mismatches;
  int   fed_items;
  int   skipped_items;
  int   raw_checked;
  int   ok_runs;
  int   err_runs;
  int   signatures;
  int   send_idle_odds;
  logic quiet;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin : watchdog
    #4_000_000;
    $display("Timeout with %0d results still expected", pending_raw.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void clear_parse();
    sig_phase  = PH_SEQ_TAG;
    int_left   = '0;
    seen_bytes = '0;
    sig_failed = 1'b0;
    strip_zero = 1'b0;
  endfunction

  function automatic void push_raw(input logic [7:0] data, input kind_t kind, input logic last);
    raw_item_t item;
    item.data = data;
    item.kind = kind;
    item.last = last;
    pending_raw.push_back(item);
  endfunction

  // Phase after the integer whose length or data phase is current
  function automatic phase_t next_after_int(input phase_t ph);
    return (ph == PH_R_LEN || ph == PH_R_DATA) ? PH_S_TAG : PH_DONE;
  endfunction

  // Expected results of one accepted DER byte
  function automatic void predict_raw_bytes(input logic [7:0] b, input logic eos);
    logic good;
    if (!eos && (sig_failed || sig_phase == PH_DONE)) skipped_items++;
    else fed_items++;
    if (seen_bytes < MIN_TOTAL) seen_bytes++;
    if (!sig_failed) begin
      case (sig_phase)
        PH_SEQ_TAG: begin
          if (b != SEQ_TAG) sig_failed = 1'b1;
          else sig_phase = PH_SEQ_LEN;
        end
        PH_SEQ_LEN: sig_phase = PH_R_TAG;
        PH_R_TAG, PH_S_TAG: begin
          if (b != INT_TAG) sig_failed = 1'b1;
          else sig_phase = (sig_phase == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
        end
        PH_R_LEN, PH_S_LEN: begin
          if (b > LEN_MAX) begin
            sig_failed = 1'b1;
          end else if (b == LEN_MAX) begin
            int_left   = LEFT_W'(b);
            strip_zero = 1'b1;
            sig_phase  = (sig_phase == PH_R_LEN) ? PH_R_DATA : PH_S_DATA;
          end else begin
            // leading zero padding goes out at the length byte
            for (int i = 0; i < COORD_BYTES - int'(b); i++) push_raw(8'h00, KIND_BYTE, 1'b0);
            int_left = LEFT_W'(b);
            if (b != 8'h00) sig_phase = (sig_phase == PH_R_LEN) ? PH_R_DATA : PH_S_DATA;
            else sig_phase = next_after_int(sig_phase);
          end
        end
        PH_R_DATA, PH_S_DATA: begin
          if (strip_zero) begin
            strip_zero = 1'b0;
            if (b != 8'h00) sig_failed = 1'b1;
            else int_left--;
          end else begin
            push_raw(b, KIND_BYTE, 1'b0);
            if (int_left != '0) int_left--;
            if (int_left == '0) sig_phase = next_after_int(sig_phase);
          end
        end
        default: ;
      endcase
    end
    if (eos) begin
      good = !sig_failed && sig_phase == PH_DONE && seen_bytes >= MIN_TOTAL;
      push_raw(8'h00, good ? KIND_OK : KIND_ERR, 1'b1);
      clear_parse();
    end
  endfunction

  // Prediction on accepted requests, then checking of accepted results
  always @(posedge clk) begin : scoreboard
    raw_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_raw_bytes(in_der_byte, in_end_of_sig);
      if (out_valid && out_ready) begin
        if (pending_raw.size() == 0) begin
          flag_mismatch($sformatf("unexpected result byte=%02h kind=%0d last=%0b",
                                  out_byte, out_result_kind, out_last_of_run));
        end else begin
          want = pending_raw.pop_front();
          if (out_byte !== want.data || out_result_kind !== want.kind ||
              out_last_of_run !== want.last)
            flag_mismatch($sformatf("expected byte=%02h kind=%0d last=%0b, got byte=%02h kind=%0d last=%0b",
                                    want.data, want.kind, want.last,
                                    out_byte, out_result_kind, out_last_of_run));
          if (want.kind == KIND_BYTE) raw_checked++;
          else if (want.kind == KIND_OK) ok_runs++;
          else err_runs++;
        end
      end
    end
  end

  // Receiver: ready stretches broken by stall bursts
  initial begin : receiver
    out_ready <= 1'b1;
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // One request, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (!quiet && $urandom_range(0, 7) < send_idle_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_der_byte   <= b;
    in_end_of_sig <= eos;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_signature();
    send_idle_odds = $urandom_range(0, 3);
    signatures++;
    for (int i = 0; i < der_stream.size(); i++)
      send_byte(der_stream[i], i == der_stream.size() - 1);
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic wait_all_raw_out();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_raw.size() != 0);
  endtask

  // Mostly short integers, with the 32 and 33 byte extremes now and then
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 4);
    if (r == 7) return $urandom_range(5, COORD_BYTES);
    if (r == 8) return COORD_BYTES;
    return COORD_BYTES + 1;
  endfunction

  // Integer TLV: tag, length, body; a 33 byte body starts with its zero byte
  function automatic void add_integer(input int len, input int body);
    der_stream.push_back(INT_TAG);
    der_stream.push_back(8'(len));
    for (int i = 0; i < body; i++)
      der_stream.push_back((i == 0 && len == COORD_BYTES + 1) ? 8'h00 : 8'($urandom));
  endfunction

  // Random signature: well-formed, corrupted, truncated, oversize length, or noise
  function automatic void make_signature();
    int flavor;
    int len;
    der_stream = {};
    flavor = $urandom_range(0, 9);
    if (flavor == 9) begin
      repeat ($urandom_range(1, 12)) der_stream.push_back(8'($urandom));
      return;
    end
    der_stream.push_back(SEQ_TAG);
    der_stream.push_back(8'($urandom));
    if (flavor == 6) begin
      add_integer($urandom_range(COORD_BYTES + 2, 255), $urandom_range(0, 3));
    end else begin
      len = pick_length();
      add_integer(len, len);
    end
    len = pick_length();
    add_integer(len, len);
    repeat ($urandom_range(0, 2)) der_stream.push_back(8'($urandom));
    if (flavor == 7) begin
      der_stream[$urandom_range(0, der_stream.size() - 1)] = 8'($urandom);
    end else if (flavor == 8) begin
      len = $urandom_range(1, der_stream.size() - 1);
      while (der_stream.size() > len) void'(der_stream.pop_back());
    end
  endfunction

  task automatic test_bad_sequence_tag();
    der_stream = '{8'hFF};
    send_signature();
  endtask

  // Both integers empty, then two trailing bytes
  task automatic test_zero_length_integers();
    der_stream = '{SEQ_TAG, 8'h06, INT_TAG, 8'h00, INT_TAG, 8'h00, 8'hFF, 8'h00};
    send_signature();
  endtask

  task automatic test_length_too_large();
    der_stream = '{SEQ_TAG, 8'h00, INT_TAG, LEN_MAX + 8'd1};
    send_signature();
  endtask

  // 33 byte integer whose first byte is not zero
  task automatic test_overlong_without_zero();
    der_stream = '{SEQ_TAG, 8'h45, INT_TAG, LEN_MAX, 8'h01};
    send_signature();
  endtask

  task automatic test_bad_integer_tag();
    der_stream = '{SEQ_TAG, 8'h44, 8'h03};
    send_signature();
  endtask

  // Stream ends in the middle of S
  task automatic test_early_end();
    der_stream = '{SEQ_TAG, 8'h44, INT_TAG, 8'h01, 8'h80, INT_TAG, 8'h05, 8'h7F};
    send_signature();
  endtask

  // Sender holds off until the block has drained completely
  task automatic test_drain_pause();
    make_signature();
    send_signature();
    wait_all_raw_out();
  endtask

  // Target counts every accepted request, parsed or ignored
  task automatic test_random_signatures(input int target);
    int start;
    start = fed_items + skipped_items;
    while (fed_items + skipped_items - start < target) begin
      make_signature();
      send_signature();
      if ($urandom_range(0, 7) == 0) wait_all_raw_out();
    end
  endtask

  // Closing stretch with neither side idling
  task automatic test_quiet_tail(input int target);
    quiet = 1'b1;
    test_random_signatures(target);
  endtask

  initial begin : main
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_der_byte   <= 8'h00;
    in_end_of_sig <= 1'b0;
    quiet          = 1'b0;
    mismatches     = 0;
    fed_items      = 0;
    skipped_items  = 0;
    raw_checked    = 0;
    ok_runs        = 0;
    err_runs       = 0;
    signatures     = 0;
    send_idle_odds = 0;
    clear_parse();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bad_sequence_tag();
    test_zero_length_integers();
    test_length_too_large();
    test_overlong_without_zero();
    test_bad_integer_tag();
    test_early_end();
    test_drain_pause();
    test_random_signatures(190);
    test_quiet_tail(30);

    wait_all_raw_out();
    repeat (16) @(posedge clk);

    $display("Sent %0d signatures (%0d parsed bytes, %0d ignored bytes).",
             signatures, fed_items, skipped_items);
    $display("Checked %0d raw bytes, %0d good and %0d rejected signatures, %0d mismatches.",
             raw_checked, ok_runs, err_runs, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/edsr_pkg.sv
sv/edsr_front.sv
sv/edsr_queue.sv
sv/edsr_back.sv
sv/ecdsa_der_to_raw_signature_core.sv
dv/ecdsa_der_to_raw_signature_core_test.sv
